// ----- sv/tks_pkg.sv -----
// Shared types, codes and constants for the top-k score tracker.
package tks_pkg;

   localparam int SCORE_W           = 32;
   localparam int ID_W              = 32;
   localparam int RANK_W            = 5;
   localparam int K_ENTRIES_DEFAULT = 32;

   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_READOUT = 1'b1;

   typedef enum logic [1:0] {
      OUT_APPEND  = 2'd0,
      OUT_REPLACE = 2'd1,
      OUT_REJECT  = 2'd2,
      OUT_READOUT = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      POS_HOLD,
      POS_ZERO,
      POS_COUNT,
      POS_INC,
      POS_DEC
   } pos_op_type;

   // Read address relative to the next value of the position register.
   typedef enum logic [1:0] {
      RD_AT_NEXT,
      RD_ABOVE_NEXT,
      RD_BELOW_NEXT
   } rd_sel_type;

   typedef enum logic {
      WR_FROM_READ,
      WR_FROM_NEW
   } wr_sel_type;

   typedef struct packed {
      logic        latch;
      pos_op_type  pos_op;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        rsp_load;
      outcome_type rsp_outcome;
      logic        count_inc;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic new_lt_rd;
      logic new_gt_min;
      logic pos_top;
      logic pos_below_top;
      logic pos_is_one;
      logic pos_is_last;
      logic out_free;
   } status_type;

endpackage

// ----- sv/tks_datapath.sv -----
// Datapath of the top-k score tracker: entry memory, position and count, result register.
module tks_datapath #(
   parameter int K_ENTRIES = tks_pkg::K_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tks_pkg::cmd_type                    cmd,
   output tks_pkg::status_type                 status,
   input  logic signed [tks_pkg::SCORE_W-1:0]  req_score,
   input  logic        [tks_pkg::ID_W-1:0]     req_vector_id,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tks_pkg::outcome_type                rsp_outcome,
   output logic signed [tks_pkg::SCORE_W-1:0]  rsp_entry_score,
   output logic        [tks_pkg::ID_W-1:0]     rsp_entry_id,
   output logic        [tks_pkg::RANK_W-1:0]   rsp_entry_rank,
   output logic                                rsp_last
);
   import tks_pkg::*;

   localparam int AW = (K_ENTRIES > 1) ? $clog2(K_ENTRIES) : 1;
   localparam int CW = $clog2(K_ENTRIES + 1);
   localparam int TOP_POS   = K_ENTRIES - 1;
   localparam int BELOW_TOP = (K_ENTRIES > 1) ? K_ENTRIES - 2 : 0;

   logic signed [SCORE_W-1:0] score_mem [K_ENTRIES];
   logic        [ID_W-1:0]    id_mem    [K_ENTRIES];

   logic signed [SCORE_W-1:0] new_score_ff, rd_score_ff, wr_score;
   logic        [ID_W-1:0]    new_id_ff, rd_id_ff, wr_id;
   logic        [AW-1:0]      pos_ff, pos_in, rd_addr;
   logic        [CW-1:0]      count_ff, count_in;

   logic                      rsp_valid_ff;
   outcome_type               rsp_outcome_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic        [ID_W-1:0]    rsp_id_ff;
   logic        [RANK_W-1:0]  rsp_rank_ff;
   logic                      rsp_last_ff;

   always_comb begin
      case (cmd.pos_op)
         POS_HOLD:  pos_in = pos_ff;
         POS_ZERO:  pos_in = '0;
         POS_COUNT: pos_in = AW'(count_ff);
         POS_INC:   pos_in = pos_ff + AW'(1);
         POS_DEC:   pos_in = pos_ff - AW'(1);
         default:   pos_in = pos_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_AT_NEXT:    rd_addr = pos_in;
         RD_ABOVE_NEXT: rd_addr = pos_in + AW'(1);
         RD_BELOW_NEXT: rd_addr = pos_in - AW'(1);
         default:       rd_addr = pos_in;
      endcase
   end

   assign wr_score = (cmd.wr_sel == WR_FROM_NEW) ? new_score_ff : rd_score_ff;
   assign wr_id    = (cmd.wr_sel == WR_FROM_NEW) ? new_id_ff    : rd_id_ff;
   assign count_in = cmd.count_inc ? count_ff + CW'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         score_mem[pos_ff] <= wr_score;
         id_mem[pos_ff]    <= wr_id;
      end
      if (cmd.rd_en) begin
         rd_score_ff <= score_mem[rd_addr];
         rd_id_ff    <= id_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         new_score_ff <= req_score;
         new_id_ff    <= req_vector_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   always_comb begin
      status.count_zero    = (count_ff == '0);
      status.count_full    = (count_ff == CW'(K_ENTRIES));
      status.new_lt_rd     = (new_score_ff < rd_score_ff) ||
                             ((new_score_ff == rd_score_ff) && (new_id_ff < rd_id_ff));
      status.new_gt_min    = (new_score_ff > rd_score_ff);
      status.pos_top       = (pos_ff == AW'(TOP_POS));
      status.pos_below_top = (pos_ff == AW'(BELOW_TOP));
      status.pos_is_one    = (pos_ff == AW'(1));
      status.pos_is_last   = ((CW'(pos_ff) + CW'(1)) == count_ff);
      status.out_free      = !rsp_valid_ff || !rsp_stall;
   end

   // Insert results carry only the outcome; the entry fields stay zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_outcome_ff <= cmd.rsp_outcome;
         if (cmd.rsp_outcome == OUT_READOUT) begin
            rsp_score_ff <= rd_score_ff;
            rsp_id_ff    <= rd_id_ff;
            rsp_rank_ff  <= RANK_W'(pos_ff);
            rsp_last_ff  <= status.pos_is_last;
         end else begin
            rsp_score_ff <= '0;
            rsp_id_ff    <= '0;
            rsp_rank_ff  <= '0;
            rsp_last_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_entry_score = rsp_score_ff;
   assign rsp_entry_id    = rsp_id_ff;
   assign rsp_entry_rank  = rsp_rank_ff;
   assign rsp_last        = rsp_last_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(K_ENTRIES))
      else $error("held count exceeds the store depth");

   a_no_collision: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.rd_en) |-> (rd_addr != pos_ff))
      else $error("memory read and write hit the same entry");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> ({1'b0, rd_addr} < (AW + 1)'(K_ENTRIES)))
      else $error("memory read beyond the store depth");

endmodule

// ----- sv/tks_ctrl.sv -----
// Controller state machine of the top-k score tracker.
module tks_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  tks_pkg::status_type status,
   output tks_pkg::cmd_type    cmd
);
   import tks_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MIN_CHK,
      S_SCAN_UP,
      S_SCAN_DN,
      S_PLACE,
      S_EMIT,
      S_RD_DATA
   } state_type;

   state_type   state_ff, state_in;
   outcome_type outcome_ff, outcome_in;
   logic        accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      outcome_in      = outcome_ff;
      cmd.latch       = 1'b0;
      cmd.pos_op      = POS_HOLD;
      cmd.rd_en       = 1'b0;
      cmd.rd_sel      = RD_AT_NEXT;
      cmd.wr_en       = 1'b0;
      cmd.wr_sel      = WR_FROM_NEW;
      cmd.rsp_load    = 1'b0;
      cmd.rsp_outcome = outcome_ff;
      cmd.count_inc   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               if (req_type == REQ_READOUT) begin
                  if (!status.count_zero) begin
                     cmd.pos_op = POS_ZERO;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_RD_DATA;
                  end
               end else if (!status.count_full) begin
                  outcome_in = OUT_APPEND;
                  if (status.count_zero) begin
                     cmd.pos_op = POS_ZERO;
                     state_in   = S_PLACE;
                  end else begin
                     cmd.pos_op = POS_COUNT;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_BELOW_NEXT;
                     state_in   = S_SCAN_DN;
                  end
               end else begin
                  cmd.pos_op = POS_ZERO;
                  cmd.rd_en  = 1'b1;
                  state_in   = S_MIN_CHK;
               end
            end
         end
         S_MIN_CHK: begin
            // Equal to the smallest kept score is not good enough to enter.
            if (!status.new_gt_min) begin
               outcome_in = OUT_REJECT;
               state_in   = S_EMIT;
            end else begin
               outcome_in = OUT_REPLACE;
               if (status.pos_top) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_ABOVE_NEXT;
                  state_in   = S_SCAN_UP;
               end
            end
         end
         S_SCAN_UP: begin
            // Entries not above the new word slide down over the dropped minimum.
            if (!status.new_lt_rd) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_FROM_READ;
               cmd.pos_op = POS_INC;
               if (status.pos_below_top) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_ABOVE_NEXT;
               end
            end else begin
               cmd.wr_en = 1'b1;
               state_in  = S_EMIT;
            end
         end
         S_SCAN_DN: begin
            if (status.new_lt_rd) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_FROM_READ;
               cmd.pos_op = POS_DEC;
               if (status.pos_is_one) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_BELOW_NEXT;
               end
            end else begin
               cmd.wr_en = 1'b1;
               state_in  = S_EMIT;
            end
         end
         S_PLACE: begin
            cmd.wr_en = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.rsp_load  = 1'b1;
               cmd.count_inc = (outcome_ff == OUT_APPEND);
               state_in      = S_IDLE;
            end
         end
         S_RD_DATA: begin
            if (status.out_free) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_outcome = OUT_READOUT;
               if (status.pos_is_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.pos_op = POS_INC;
                  cmd.rd_en  = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         outcome_ff <= OUT_APPEND;
      end else begin
         state_ff   <= state_in;
         outcome_ff <= outcome_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.out_free)
      else $error("result register loaded while still occupied");

   a_append_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> !status.count_full)
      else $error("append counted into a full store");

   a_readout_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_DATA) |-> !status.count_zero)
      else $error("readout running on an empty store");

endmodule

// ----- sv/top_k_score_tracker.sv -----
// Top level of the top-k score tracker: controller and datapath joined.
//
//   channel   direction  handshake              word
//   req_      in         req_valid / req_stall  req_type, req_score, req_vector_id
//   rsp_      out        rsp_valid / rsp_stall  rsp_outcome, rsp_entry_score,
//                                               rsp_entry_id, rsp_entry_rank, rsp_last
//
// One request is worked at a time through an entry memory with one read port, one write
// port and a registered read. Appends and replacements move entries one at a time, a
// rejection moves none, and a readout gives one word per cycle while rsp_stall is low.
// Reset clears the held count and position, not the memory; it needs no clearing pass.
// A stalled result holds the controller before it loads the next word, and a new
// request is taken as soon as the previous one has loaded its last word.
module top_k_score_tracker #(
   parameter int K_ENTRIES = tks_pkg::K_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic signed [tks_pkg::SCORE_W-1:0]  req_score,
   input  logic        [tks_pkg::ID_W-1:0]     req_vector_id,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tks_pkg::outcome_type                rsp_outcome,
   output logic signed [tks_pkg::SCORE_W-1:0]  rsp_entry_score,
   output logic        [tks_pkg::ID_W-1:0]     rsp_entry_id,
   output logic        [tks_pkg::RANK_W-1:0]   rsp_entry_rank,
   output logic                                rsp_last
);
   import tks_pkg::*;

   cmd_type    cmd;
   status_type status;

   tks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd)
   );

   tks_datapath #(
      .K_ENTRIES (K_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_score       (req_score),
      .req_vector_id   (req_vector_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_outcome     (rsp_outcome),
      .rsp_entry_score (rsp_entry_score),
      .rsp_entry_id    (rsp_entry_id),
      .rsp_entry_rank  (rsp_entry_rank),
      .rsp_last        (rsp_last)
   );

endmodule
